// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the block cache RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled in reset.
`define LBC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, checked during reset as well.
`define LBC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/lbc_pkg.sv =====
// Types, constants and codes of the LFU block cache.
package lbc_pkg;

    localparam int ENTRIES     = 64;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int BLOCK_WORDS = 32;
    localparam int BEAT_W      = 5;
    localparam int CFG_W       = 7;
    localparam int CNT_W       = 32;
    localparam int DISK_W      = 4;
    localparam int BLK_W       = 8;
    localparam int WORD_W      = 64;
    localparam int DADDR_W     = IDX_W + $clog2(BLOCK_WORDS);
    localparam int PADDR_W     = 3;

    localparam logic [CFG_W-1:0] EIU_RESET = CFG_W'(ENTRIES);
    localparam logic [CFG_W-1:0] EIU_MIN   = CFG_W'(2);

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_DUP  = 2'd2;

    localparam logic REG_ENTRIES_IN_USE = 1'b0;

    typedef struct packed {
        logic [DISK_W-1:0] disk;
        logic [BLK_W-1:0]  blk;
        logic [CNT_W-1:0]  count;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_EXEC,
        ST_STREAM_RD,
        ST_STREAM_LD
    } state_t;

endpackage

// ===== hw/rtl/lfu_block_cache_top.sv =====
// Top level of the LFU block cache: control, tag scan and data streaming.
//
// channel  dir  handshake          words
// in       in   in_valid/in_stall  op, disk_id, block_id, beat_index, write_word
// out      out  out_valid/out_stall status, read_word, read_beat, last_beat, counters
// cfg      in   APB psel/penable   entries_in_use at byte address 0
//
// One item at a time. A lookup or a beat-0 write scans the entry RAM one entry
// per cycle over the entries in use. A lookup hit then streams 32 words, each a
// data RAM read, then a load that waits while the output is stalled.
// Reset clears valid bits, counters and control; no clearing pass is needed.
// A stalled output word holds; the next item is taken while it waits.
module lfu_block_cache_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   op,
    input  logic [lbc_pkg::DISK_W-1:0]   disk_id,
    input  logic [lbc_pkg::BLK_W-1:0]    block_id,
    input  logic [lbc_pkg::BEAT_W-1:0]   beat_index,
    input  logic [lbc_pkg::WORD_W-1:0]   write_word,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   status,
    output logic [lbc_pkg::WORD_W-1:0]   read_word,
    output logic [lbc_pkg::BEAT_W-1:0]   read_beat,
    output logic                         last_beat,
    output logic [31:0]                  lookups_seen,
    output logic [31:0]                  hits_seen,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lbc_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    import lbc_pkg::*;
`include "assert_macros.svh"

    state_t state_reg, state_next;

    logic [CFG_W-1:0]   eiu_reg, eiu_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]   open_slot_reg, open_slot_next;
    logic               wa_reg, wa_next;
    logic [31:0]        lookup_total_reg, lookup_total_next;
    logic [31:0]        hit_total_reg, hit_total_next;

    logic [1:0]         op_reg;
    logic [DISK_W-1:0]  disk_reg;
    logic [BLK_W-1:0]   blk_reg;
    logic [BEAT_W-1:0]  beat_reg;
    logic [WORD_W-1:0]  word_reg;

    logic [IDX_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic               match_found_reg, match_found_next;
    logic [IDX_W-1:0]   match_idx_reg, match_idx_next;
    logic [CNT_W-1:0]   match_cnt_reg, match_cnt_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]   min_idx_reg, min_idx_next;
    logic [CNT_W-1:0]   min_cnt_reg, min_cnt_next;
    logic [BEAT_W-1:0]  beat_cnt_reg, beat_cnt_next;

    logic               out_valid_reg, out_valid_next;
    logic [1:0]         status_reg, status_next;
    logic [WORD_W-1:0]  read_word_reg, read_word_next;
    logic [BEAT_W-1:0]  read_beat_reg, read_beat_next;
    logic               last_beat_reg, last_beat_next;
    logic [31:0]        lookups_reg, lookups_next;
    logic [31:0]        hits_reg, hits_next;

    logic               ent_we, ent_re;
    logic [IDX_W-1:0]   ent_waddr, ent_raddr;
    entry_t             ent_wdata, ent_q;
    logic [$bits(entry_t)-1:0] ent_q_raw;

    logic               dat_we, dat_re;
    logic [DADDR_W-1:0] dat_waddr, dat_raddr;
    logic [WORD_W-1:0]  dat_wdata, dat_q;

    logic               in_fire, cfg_wr, out_free, exec_go, need_scan;
    logic               beat_bad, beat_zero, last_scan, stream_last;
    logic [CFG_W-1:0]   n_act;
    logic [IDX_W-1:0]   last_idx;
    logic [IDX_W-1:0]   pick_idx;

    lbc_ram #(.DEPTH(ENTRIES), .WIDTH($bits(entry_t))) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (ent_re),
        .raddr (ent_raddr),
        .rdata (ent_q_raw)
    );
    assign ent_q = entry_t'(ent_q_raw);

    lbc_ram #(.DEPTH(ENTRIES * BLOCK_WORDS), .WIDTH(WORD_W)) u_data_ram (
        .clk   (clk),
        .we    (dat_we),
        .waddr (dat_waddr),
        .wdata (dat_wdata),
        .re    (dat_re),
        .raddr (dat_raddr),
        .rdata (dat_q)
    );

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_ENTRIES_IN_USE);
    assign prdata   = (paddr[2] == REG_ENTRIES_IN_USE) ? {{(32-CFG_W){1'b0}}, eiu_reg} : 32'd0;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign exec_go  = (state_reg == ST_EXEC) && out_free;

    assign n_act = (eiu_reg < EIU_MIN) ? EIU_MIN :
                   (eiu_reg > CFG_W'(ENTRIES)) ? CFG_W'(ENTRIES) : eiu_reg;
    assign last_idx  = IDX_W'(n_act - CFG_W'(1));
    assign last_scan = (scan_idx_reg == last_idx);

    assign beat_bad  = ({1'b0, beat_reg} >= (BEAT_W+1)'(BLOCK_WORDS));
    assign beat_zero = (beat_reg == '0);
    assign need_scan = (op == OP_LOOKUP) ||
                       (((op == OP_INSERT) || (op == OP_UPDATE)) && (beat_index == '0));
    assign pick_idx  = free_found_reg ? free_idx_reg : min_idx_reg;
    assign stream_last = (beat_cnt_reg == BEAT_W'(BLOCK_WORDS - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = need_scan ? ST_SCAN : ST_EXEC;
                end
            end
            ST_SCAN:
            begin
                if (last_scan)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = (op_reg == OP_LOOKUP && match_found_reg) ?
                                 ST_STREAM_RD : ST_IDLE;
                end
            end
            ST_STREAM_RD:
            begin
                state_next = ST_STREAM_LD;
            end
            ST_STREAM_LD:
            begin
                if (out_free)
                begin
                    state_next = stream_last ? ST_IDLE : ST_STREAM_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        eiu_next          = eiu_reg;
        valid_next        = valid_reg;
        open_slot_next    = open_slot_reg;
        wa_next           = wa_reg;
        lookup_total_next = lookup_total_reg;
        hit_total_next    = hit_total_reg;
        scan_idx_next     = scan_idx_reg;
        cmp_vld_next      = 1'b0;
        cmp_idx_next      = cmp_idx_reg;
        match_found_next  = match_found_reg;
        match_idx_next    = match_idx_reg;
        match_cnt_next    = match_cnt_reg;
        free_found_next   = free_found_reg;
        free_idx_next     = free_idx_reg;
        min_idx_next      = min_idx_reg;
        min_cnt_next      = min_cnt_reg;
        beat_cnt_next     = beat_cnt_reg;
        out_valid_next    = out_valid_reg && out_stall;
        status_next       = status_reg;
        read_word_next    = read_word_reg;
        read_beat_next    = read_beat_reg;
        last_beat_next    = last_beat_reg;
        lookups_next      = lookups_reg;
        hits_next         = hits_reg;
        ent_we            = 1'b0;
        ent_waddr         = match_idx_reg;
        ent_wdata         = '{disk: disk_reg, blk: blk_reg, count: CNT_W'(1)};
        ent_re            = 1'b0;
        ent_raddr         = scan_idx_reg;
        dat_we            = 1'b0;
        dat_waddr         = {open_slot_reg, beat_reg};
        dat_wdata         = word_reg;
        dat_re            = 1'b0;
        dat_raddr         = {match_idx_reg, beat_cnt_reg};

        if (cfg_wr)
        begin
            eiu_next   = pwdata[CFG_W-1:0];
            valid_next = '0;
            wa_next    = 1'b0;
        end

        if (in_fire)
        begin
            scan_idx_next    = '0;
            match_found_next = 1'b0;
            free_found_next  = 1'b0;
            beat_cnt_next    = '0;
        end

        if (state_reg == ST_SCAN)
        begin
            ent_re        = 1'b1;
            cmp_vld_next  = 1'b1;
            cmp_idx_next  = scan_idx_reg;
            scan_idx_next = scan_idx_reg + IDX_W'(1);
        end

        if (cmp_vld_reg)
        begin
            if (valid_reg[cmp_idx_reg] && !match_found_reg &&
                ent_q.disk == disk_reg && ent_q.blk == blk_reg)
            begin
                match_found_next = 1'b1;
                match_idx_next   = cmp_idx_reg;
                match_cnt_next   = ent_q.count;
            end
            if (!valid_reg[cmp_idx_reg] && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = cmp_idx_reg;
            end
            if (cmp_idx_reg == '0 || ent_q.count < min_cnt_reg)
            begin
                min_idx_next = cmp_idx_reg;
                min_cnt_next = ent_q.count;
            end
        end

        if (exec_go)
        begin
            out_valid_next = 1'b1;
            status_next    = STAT_MISS;
            read_word_next = '0;
            read_beat_next = beat_reg;
            last_beat_next = 1'b1;
            ent_wdata.count = (match_cnt_reg != '1) ? match_cnt_reg + CNT_W'(1) : match_cnt_reg;
            case (op_reg)
                OP_LOOKUP:
                begin
                    lookup_total_next = lookup_total_reg + 32'd1;
                    read_beat_next    = '0;
                    if (match_found_reg)
                    begin
                        out_valid_next = 1'b0;
                        hit_total_next = hit_total_reg + 32'd1;
                        ent_we         = 1'b1;
                    end
                end
                OP_INSERT, OP_UPDATE:
                begin
                    if (beat_bad)
                    begin
                        status_next = STAT_MISS;
                    end
                    else if (beat_zero && op_reg == OP_INSERT)
                    begin
                        if (match_found_reg)
                        begin
                            wa_next     = 1'b0;
                            status_next = STAT_DUP;
                        end
                        else
                        begin
                            ent_we               = 1'b1;
                            ent_waddr            = pick_idx;
                            ent_wdata.count      = CNT_W'(1);
                            valid_next[pick_idx] = 1'b1;
                            open_slot_next       = pick_idx;
                            wa_next              = 1'b1;
                            dat_we               = 1'b1;
                            dat_waddr            = {pick_idx, beat_reg};
                            status_next          = STAT_OK;
                        end
                    end
                    else if (beat_zero)
                    begin
                        if (match_found_reg)
                        begin
                            ent_we         = 1'b1;
                            open_slot_next = match_idx_reg;
                            wa_next        = 1'b1;
                            dat_we         = 1'b1;
                            dat_waddr      = {match_idx_reg, beat_reg};
                            status_next    = STAT_OK;
                        end
                        else
                        begin
                            wa_next = 1'b0;
                        end
                    end
                    else if (wa_reg)
                    begin
                        dat_we      = 1'b1;
                        status_next = STAT_OK;
                    end
                end
                default:
                begin
                    status_next = STAT_MISS;
                end
            endcase
            lookups_next = lookup_total_next;
            hits_next    = hit_total_next;
        end

        if (state_reg == ST_STREAM_RD)
        begin
            dat_re = 1'b1;
        end

        if (state_reg == ST_STREAM_LD && out_free)
        begin
            out_valid_next = 1'b1;
            status_next    = STAT_OK;
            read_word_next = dat_q;
            read_beat_next = beat_cnt_reg;
            last_beat_next = stream_last;
            lookups_next   = lookup_total_reg;
            hits_next      = hit_total_reg;
            beat_cnt_next  = beat_cnt_reg + BEAT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            eiu_reg          <= EIU_RESET;
            valid_reg        <= '0;
            open_slot_reg    <= '0;
            wa_reg           <= 1'b0;
            lookup_total_reg <= '0;
            hit_total_reg    <= '0;
            cmp_vld_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            eiu_reg          <= eiu_next;
            valid_reg        <= valid_next;
            open_slot_reg    <= open_slot_next;
            wa_reg           <= wa_next;
            lookup_total_reg <= lookup_total_next;
            hit_total_reg    <= hit_total_next;
            cmp_vld_reg      <= cmp_vld_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg   <= op;
            disk_reg <= disk_id;
            blk_reg  <= block_id;
            beat_reg <= beat_index;
            word_reg <= write_word;
        end
        scan_idx_reg    <= scan_idx_next;
        cmp_idx_reg     <= cmp_idx_next;
        match_found_reg <= match_found_next;
        match_idx_reg   <= match_idx_next;
        match_cnt_reg   <= match_cnt_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        min_idx_reg     <= min_idx_next;
        min_cnt_reg     <= min_cnt_next;
        beat_cnt_reg    <= beat_cnt_next;
        status_reg      <= status_next;
        read_word_reg   <= read_word_next;
        read_beat_reg   <= read_beat_next;
        last_beat_reg   <= last_beat_next;
        lookups_reg     <= lookups_next;
        hits_reg        <= hits_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign read_word    = read_word_reg;
    assign read_beat    = read_beat_reg;
    assign last_beat    = last_beat_reg;
    assign lookups_seen = lookups_reg;
    assign hits_seen    = hits_reg;

    `LBC_ASSERT(a_stream_holds, (state_reg == ST_STREAM_LD && !out_free) |=> (state_reg == ST_STREAM_LD), "stream word dropped while output busy")
    `LBC_ASSERT(a_hit_counted, (exec_go && op_reg == OP_LOOKUP && match_found_reg) |=> (hit_total_reg == $past(hit_total_reg) + 32'd1), "lookup hit not counted")
    `LBC_ASSERT(a_cfg_clears, cfg_wr |=> (valid_reg == '0 && !wa_reg), "config write did not clear valid bits")

endmodule

// ===== hw/rtl/lbc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module lbc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the LFU block cache: directed table, random block traffic, APB config.
`timescale 1ns / 1ps

module testbench;
    import lbc_pkg::*;

    typedef struct {
        logic [1:0]        st;
        logic [WORD_W-1:0] word;
        logic [BEAT_W-1:0] beat;
        logic              last;
        logic [31:0]       lk;
        logic [31:0]       ht;
    } word_t;

    typedef struct {
        logic [1:0]        op;
        logic [DISK_W-1:0] disk;
        logic [BLK_W-1:0]  blk;
        logic [BEAT_W-1:0] beat;
        logic [WORD_W-1:0] data;
        bit                typed;
        logic [1:0]        st;
    } row_t;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int WATCH_LIMIT = 20000;

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    logic [1:0] op, status;
    logic [DISK_W-1:0] disk_id;
    logic [BLK_W-1:0] block_id;
    logic [BEAT_W-1:0] beat_index, read_beat;
    logic [WORD_W-1:0] write_word, read_word;
    logic last_beat;
    logic [31:0] lookups_seen, hits_seen, pwdata, prdata;
    logic psel, penable, pwrite, pready;
    logic [PADDR_W-1:0] paddr;

    lfu_block_cache_top DUT (.*);

    // cache image
    logic [6:0]        eiu;
    bit                vld [ENTRIES];
    logic [DISK_W-1:0] tag_d [ENTRIES];
    logic [BLK_W-1:0]  tag_b [ENTRIES];
    logic [CNT_W-1:0]  uses [ENTRIES];
    logic [WORD_W-1:0] store [ENTRIES*BLOCK_WORDS];
    bit                filled [ENTRIES*BLOCK_WORDS];
    int                slot_open;
    bit                wr_ok;
    logic [31:0]       n_lookups, n_hits;

    word_t expected_words[$];
    int errors, items_sent, words_seen, hold_cycles, idle_cnt;
    bit calm;
    logic [DISK_W-1:0] pool_d [12];
    logic [BLK_W-1:0]  pool_b [12];

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic int span();
        if (eiu < 2) return 2;
        if (eiu > ENTRIES) return ENTRIES;
        return int'(eiu);
    endfunction

    function automatic int find_slot(logic [DISK_W-1:0] d, logic [BLK_W-1:0] b);
        for (int i = 0; i < span(); i++)
            if (vld[i] && tag_d[i] == d && tag_b[i] == b) return i;
        return -1;
    endfunction

    function automatic bit block_complete(int s);
        for (int k = 0; k < BLOCK_WORDS; k++)
            if (!filled[s*BLOCK_WORDS+k]) return 0;
        return 1;
    endfunction

    function automatic void push_word(logic [1:0] st, logic [WORD_W-1:0] w,
                                      logic [BEAT_W-1:0] bt, logic lst);
        word_t r;
        r.st = st; r.word = w; r.beat = bt; r.last = lst; r.lk = n_lookups; r.ht = n_hits;
        expected_words.push_back(r);
    endfunction

    function automatic void bump_use(int s);
        if (uses[s] != '1) uses[s] = uses[s] + CNT_W'(1);
    endfunction

    function automatic void predict_cache(row_t it);
        int hit, pick;
        bit found;
        if (it.op == OP_LOOKUP) begin
            n_lookups++;
            hit = find_slot(it.disk, it.blk);
            if (hit < 0) begin
                push_word(STAT_MISS, '0, '0, 1'b1);
                return;
            end
            n_hits++;
            bump_use(hit);
            for (int k = 0; k < BLOCK_WORDS; k++)
                push_word(STAT_OK, store[hit*BLOCK_WORDS+k], BEAT_W'(k), k == BLOCK_WORDS-1);
            return;
        end
        if (it.op == OP_NONE || it.beat >= BLOCK_WORDS) begin
            push_word(STAT_MISS, '0, it.beat, 1'b1);
            return;
        end
        if (it.beat == 0) begin
            hit = find_slot(it.disk, it.blk);
            if (it.op == OP_INSERT) begin
                if (hit >= 0) begin
                    wr_ok = 0;
                    push_word(STAT_DUP, '0, it.beat, 1'b1);
                    return;
                end
                pick = 0; found = 0;
                for (int i = 0; i < span(); i++)
                    if (!found && !vld[i]) begin pick = i; found = 1; end
                if (!found)
                    for (int i = 1; i < span(); i++)
                        if (uses[i] < uses[pick]) pick = i;
                vld[pick] = 1; tag_d[pick] = it.disk; tag_b[pick] = it.blk; uses[pick] = 1;
                slot_open = pick;
                wr_ok = 1;
            end else begin
                if (hit < 0) begin
                    wr_ok = 0;
                    push_word(STAT_MISS, '0, it.beat, 1'b1);
                    return;
                end
                slot_open = hit;
                wr_ok = 1;
                bump_use(hit);
            end
        end else if (!wr_ok) begin
            push_word(STAT_MISS, '0, it.beat, 1'b1);
            return;
        end
        store[slot_open*BLOCK_WORDS+it.beat] = it.data;
        filled[slot_open*BLOCK_WORDS+it.beat] = 1;
        push_word(STAT_OK, '0, it.beat, 1'b1);
    endfunction

    task automatic send_word(row_t it);
        int s;
        // a hit on a block with unwritten beats would read undefined data
        if (it.op == OP_LOOKUP) begin
            s = find_slot(it.disk, it.blk);
            if (s >= 0 && !block_complete(s)) begin
                it.op = OP_INSERT; it.beat = 0; it.typed = 0;
            end
        end
        while (!calm && $urandom_range(99) < 33) begin
            in_valid <= 0;
            @(posedge clk);
        end
        op <= it.op; disk_id <= it.disk; block_id <= it.blk;
        beat_index <= it.beat; write_word <= it.data; in_valid <= 1;
        do @(posedge clk); while (in_stall);
        predict_cache(it);
        if (it.typed) expected_words[$].st = it.st;
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 0;
        wait (expected_words.size() == 0);
        repeat (100) @(posedge clk);
    endtask

    task automatic apb_write(logic [31:0] v);
        @(posedge clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= '0; pwdata <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        eiu = v[6:0];
        for (int i = 0; i < ENTRIES; i++) vld[i] = 0;
        wr_ok = 0;
        @(posedge clk);
        psel <= 1; paddr <= '0;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        if (prdata[6:0] !== eiu) begin
            $error("entries_in_use readback exp %0d act %0d", eiu, prdata[6:0]);
            errors++;
        end
        psel <= 0; penable <= 0;
    endtask

    function automatic row_t mk(logic [1:0] o, logic [DISK_W-1:0] d, logic [BLK_W-1:0] b,
                                logic [BEAT_W-1:0] bt, logic [WORD_W-1:0] w);
        row_t r;
        r.op = o; r.disk = d; r.blk = b; r.beat = bt; r.data = w; r.typed = 0; r.st = '0;
        return r;
    endfunction

    task automatic send_block(bit upd, int t, bit broken);
        int stop;
        stop = broken ? $urandom_range(BLOCK_WORDS-1) : BLOCK_WORDS;
        for (int k = 0; k < stop; k++)
            send_word(mk(upd ? OP_UPDATE : OP_INSERT, pool_d[t], pool_b[t], BEAT_W'(k),
                         {$urandom, $urandom}));
    endtask

    task automatic random_phase(int n);
        int t, sel, stop_at;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            sel = $urandom_range(99);
            t = $urandom_range(11);
            if (sel < 30) send_block(0, t, sel < 4);
            else if (sel < 45) send_block(1, t, sel < 33);
            else if (sel < 85) send_word(mk(OP_LOOKUP, pool_d[t], pool_b[t],
                                            BEAT_W'($urandom), WORD_W'($urandom)));
            else send_word(mk(2'($urandom_range(3)), DISK_W'($urandom), BLK_W'($urandom),
                              BEAT_W'($urandom), {$urandom, $urandom}));
        end
    endtask

    function automatic void chk(string f, logic [63:0] e, logic [63:0] a);
        if (e !== a) begin
            $error("%s exp %0h act %0h", f, e, a);
            errors++;
        end
    endfunction

    // result side
    initial
    begin
        word_t e;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                words_seen++;
                if (expected_words.size() == 0) begin
                    $error("unexpected result word, status %0d", status);
                    errors++;
                end else begin
                    e = expected_words.pop_front();
                    chk("status", 64'(e.st), 64'(status));
                    chk("read_word", e.word, read_word);
                    chk("read_beat", 64'(e.beat), 64'(read_beat));
                    chk("last_beat", 64'(e.last), 64'(last_beat));
                    chk("lookups_seen", 64'(e.lk), 64'(lookups_seen));
                    chk("hits_seen", 64'(e.ht), 64'(hits_seen));
                end
            end
            if (hold_cycles > 0) begin
                out_stall <= 1;
                hold_cycles--;
            end else
                out_stall <= !calm && $urandom_range(99) < 33;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt = 0;
            else idle_cnt++;
            if (idle_cnt >= WATCH_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        row_t dir [$];
        row_t r;
        logic [6:0] cfgs [7];
        cfgs = '{7'd2, 7'd0, 7'd127, 7'd1, 7'd5, 7'd64, 7'd3};
        errors = 0; items_sent = 0; words_seen = 0; hold_cycles = 0; idle_cnt = 0; calm = 0;
        rst_n = 0; in_valid = 0; out_stall = 0; op = '0; disk_id = '0; block_id = '0;
        beat_index = '0; write_word = '0; psel = 0; penable = 0; pwrite = 0;
        paddr = '0; pwdata = '0;
        eiu = EIU_RESET; slot_open = 0; wr_ok = 0; n_lookups = 0; n_hits = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            vld[i] = 0; tag_d[i] = '0; tag_b[i] = '0; uses[i] = '0;
        end
        for (int i = 0; i < ENTRIES*BLOCK_WORDS; i++)
        begin
            store[i] = '0; filled[i] = 0;
        end
        for (int i = 0; i < 12; i++)
        begin
            pool_d[i] = DISK_W'($urandom); pool_b[i] = BLK_W'($urandom);
        end
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        r = mk(OP_LOOKUP, '1, '1, '0, '0); r.typed = 1; r.st = STAT_MISS; dir.push_back(r);
        r = mk(OP_UPDATE, '1, '1, '0, '1); r.typed = 1; r.st = STAT_MISS; dir.push_back(r);
        r = mk(OP_UPDATE, '1, '1, 5'd7, '1); r.typed = 1; r.st = STAT_MISS; dir.push_back(r);
        r = mk(OP_INSERT, '1, '1, '0, '1); r.typed = 1; r.st = STAT_OK; dir.push_back(r);
        dir.push_back(mk(OP_INSERT, '1, '1, 5'd31, '0));
        r = mk(OP_INSERT, '1, '1, '0, '0); r.typed = 1; r.st = STAT_DUP; dir.push_back(r);
        r = mk(OP_INSERT, '1, '1, 5'd3, '1); r.typed = 1; r.st = STAT_MISS; dir.push_back(r);
        r = mk(OP_NONE, '0, '0, 5'd31, '1); r.typed = 1; r.st = STAT_MISS; dir.push_back(r);
        dir.push_back(mk(OP_INSERT, '0, '0, '0, 64'h5555_aaaa_0f0f_f0f0));
        dir.push_back(mk(OP_UPDATE, '1, '1, '0, 64'h8000_0000_0000_0001));
        dir.push_back(mk(OP_UPDATE, '1, '1, 5'd16, '1));
        dir.push_back(mk(OP_LOOKUP, '0, '0, '0, '0));
        foreach (dir[i]) send_word(dir[i]);
        send_block(0, 0, 0);
        send_word(mk(OP_LOOKUP, pool_d[0], pool_b[0], '0, '0));
        drain();

        for (int p = 0; p < 7; p++)
        begin
            apb_write({25'd0, cfgs[p]});
            calm = (p == 5);
            if (p == 1) hold_cycles = 400;
            random_phase(12);
            if (p == 3) begin
                in_valid <= 0;
                wait (expected_words.size() == 0);
            end
            random_phase(12);
            drain();
        end
        calm = 0;
        random_phase(24);
        drain();

        $display("Covered %0d input words and %0d result words over 8 entry-count settings,",
                 items_sent, words_seen);
        $display("with %0d lookups of which %0d hit; LFU eviction, refusals and bad beats.",
                 n_lookups, n_hits);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
